[hw/rtl/f16dt_pkg.sv]
`timescale 1ns / 1ps

package f16dt_pkg;

    // Fixed-point layout
    localparam int FRAC_BITS = 16;
    localparam int WHOLE_W   = 16;
    localparam int VFRAC_W   = 14;               // (frac * 10000) >> 16 is 0..9999

    // Decimal digit counts
    localparam int WHOLE_DIGITS = 5;
    localparam int FRAC_DIGITS  = 4;

    // Fraction scale and divide-by-ten reciprocal (exact for 16-bit values)
    localparam logic [VFRAC_W-1:0] FRAC_SCALE  = 14'd10000;
    localparam logic [16:0]        RECIP10     = 17'h0CCCD;
    localparam int                 RECIP_SHIFT = 19;

    // Characters
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // One classified number, digits stored least significant first
    typedef struct packed {
        logic                               neg;       // print a minus sign
        logic [WHOLE_DIGITS-1:0][3:0]       wdig;      // integer digits
        logic [2:0]                         wcnt;      // integer digits to print, 1..5
        logic                               fnz;       // fraction nonzero: print point
        logic [FRAC_DIGITS-1:0][3:0]        fdig;      // fraction digits
        logic [1:0]                         fstop;     // index of last printed fraction digit
    } t_rec;

endpackage

[hw/rtl/fixed16_16_to_decimal_text.sv]
// Throughput: the back emits one character per cycle while a number is queued and the
// output is not stalled by i_ready; a number has 1 to 11 characters. The front digit unit
// (five divide-by-ten steps) takes one item at a time, and a two-entry queue lets the two
// overlap. Reset (i_rst_n, synchronous, active low) empties the queue and clears the
// front and back sequencer states and the output valid flag.
`timescale 1ns / 1ps

module fixed16_16_to_decimal_text (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_fixed_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_text_char,
    output logic               o_last_char
);

    f16dt_pkg::t_rec front_rec;
    f16dt_pkg::t_rec queue_rec;
    logic            front_valid;
    logic            queue_not_full;
    logic            queue_not_empty;
    logic            back_pop;

    // Front: magnitude, scaled fraction, digit extraction
    f16dt_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_fixed_value (i_fixed_value),
        .o_rec_valid   (front_valid),
        .i_rec_ready   (queue_not_full),
        .o_rec         (front_rec)
    );

    // Queue between front and back
    f16dt_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (front_valid),
        .o_not_full  (queue_not_full),
        .i_rec       (front_rec),
        .i_pop       (back_pop),
        .o_not_empty (queue_not_empty),
        .o_rec       (queue_rec)
    );

    // Back: character sequencer and output register
    f16dt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec_valid (queue_not_empty),
        .o_rec_pop   (back_pop),
        .i_rec       (queue_rec),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_text_char (o_text_char),
        .o_last_char (o_last_char)
    );

endmodule

[hw/rtl/f16dt_front.sv]
`timescale 1ns / 1ps

module f16dt_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic signed [31:0]    i_fixed_value,
    output logic                  o_rec_valid,
    input  logic                  i_rec_ready,
    output f16dt_pkg::t_rec       o_rec
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CONV = 3'b010,
        S_PUSH = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic [2:0] r_step;

    // Working values
    logic                                 r_neg;
    logic                                 r_fnz;
    logic [f16dt_pkg::WHOLE_W-1:0]        r_w;
    logic [f16dt_pkg::VFRAC_W-1:0]        r_v;
    logic [f16dt_pkg::WHOLE_DIGITS-1:0][3:0] r_wdig;
    logic [f16dt_pkg::FRAC_DIGITS-1:0][3:0]  r_fdig;
    logic [2:0]                           r_wcnt;

    logic        accept;
    logic [31:0] mag;
    logic [29:0] scale_prod;
    logic [32:0] w_prod;
    logic [29:0] v_prod;
    logic [15:0] w_quo;
    logic [13:0] v_quo;
    logic [15:0] w_rem;
    logic [13:0] v_rem;

    assign accept  = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE);

    // Magnitude modulo 2^32 and scaled fraction
    assign mag        = i_fixed_value[31] ? (32'd0 - i_fixed_value) : i_fixed_value;
    assign scale_prod = {14'd0, mag[f16dt_pkg::FRAC_BITS-1:0]}
                        * {16'd0, f16dt_pkg::FRAC_SCALE};

    // One decimal digit per cycle from each value
    assign w_prod = {17'd0, r_w} * {16'd0, f16dt_pkg::RECIP10};
    assign v_prod = {16'd0, r_v} * {13'd0, f16dt_pkg::RECIP10[15:0]};
    assign w_quo  = {2'd0, w_prod[32:f16dt_pkg::RECIP_SHIFT]};
    assign v_quo  = {3'd0, v_prod[29:f16dt_pkg::RECIP_SHIFT]};
    assign w_rem  = r_w - ({w_quo[12:0], 3'd0} + {w_quo[14:0], 1'd0});
    assign v_rem  = r_v - ({v_quo[10:0], 3'd0} + {v_quo[12:0], 1'd0});

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (accept) n_state = S_CONV;
            S_CONV: if (r_step == 3'(f16dt_pkg::WHOLE_DIGITS - 1)) n_state = S_PUSH;
            S_PUSH: if (i_rec_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_neg  <= i_fixed_value[31];
            r_fnz  <= (mag[f16dt_pkg::FRAC_BITS-1:0] != '0);
            r_w    <= mag[31:f16dt_pkg::FRAC_BITS];
            r_v    <= scale_prod[29:f16dt_pkg::FRAC_BITS];
            r_wcnt <= 3'd1;
            r_step <= 3'd0;
        end else if (r_state == S_CONV) begin
            r_wdig[r_step] <= w_rem[3:0];
            if (r_step < 3'(f16dt_pkg::FRAC_DIGITS)) begin
                r_fdig[r_step[1:0]] <= v_rem[3:0];
            end
            if (r_w != '0) begin
                r_wcnt <= r_step + 3'd1;
            end
            r_w    <= w_quo;
            r_v    <= v_quo;
            r_step <= r_step + 3'd1;
        end
    end

    // Record toward the back
    always_comb begin
        o_rec.neg  = r_neg;
        o_rec.wdig = r_wdig;
        o_rec.wcnt = r_wcnt;
        o_rec.fnz  = r_fnz;
        o_rec.fdig = r_fdig;
        if (r_fdig[0] != 4'd0) begin
            o_rec.fstop = 2'd0;
        end else if (r_fdig[1] != 4'd0) begin
            o_rec.fstop = 2'd1;
        end else if (r_fdig[2] != 4'd0) begin
            o_rec.fstop = 2'd2;
        end else begin
            o_rec.fstop = 2'd3;
        end
    end

    assign o_rec_valid = (r_state == S_PUSH);

endmodule

[hw/rtl/f16dt_queue.sv]
`timescale 1ns / 1ps

module f16dt_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_not_full,
    input  f16dt_pkg::t_rec   i_rec,
    input  logic              i_pop,
    output logic              o_not_empty,
    output f16dt_pkg::t_rec   o_rec
);

    localparam int PW = $clog2(f16dt_pkg::QUEUE_DEPTH);

    f16dt_pkg::t_rec r_mem [f16dt_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [PW:0]     r_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_not_full  = (r_cnt != (PW+1)'(f16dt_pkg::QUEUE_DEPTH));
    assign o_not_empty = (r_cnt != '0);
    assign do_push     = i_push && o_not_full;
    assign do_pop      = i_pop && o_not_empty;
    assign o_rec       = r_mem[r_rp];

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_rec;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(f16dt_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(f16dt_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

[hw/rtl/f16dt_back.sv]
`timescale 1ns / 1ps

module f16dt_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rec_valid,
    output logic              o_rec_pop,
    input  f16dt_pkg::t_rec   i_rec,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_text_char,
    output logic              o_last_char
);

    typedef enum logic [3:0] {
        P_SIGN  = 4'b0001,
        P_WHOLE = 4'b0010,
        P_POINT = 4'b0100,
        P_FRAC  = 4'b1000
    } t_phase;

    f16dt_pkg::t_rec r_rec;
    logic            r_active;
    t_phase          r_phase, n_phase;
    logic [2:0]      r_idx, n_idx;
    logic            r_ov;
    logic [7:0]      r_char;
    logic            r_last;

    logic       slot_free;
    logic       emit;
    logic       load;
    logic [7:0] ch;
    logic       ch_last;

    assign slot_free = !r_ov || i_ready;
    assign emit      = r_active && slot_free;
    assign load      = i_rec_valid && (!r_active || (emit && ch_last));
    assign o_rec_pop = load;

    // Character for the current position and where to go next
    always_comb begin
        ch      = f16dt_pkg::CH_MINUS;
        ch_last = 1'b0;
        n_phase = r_phase;
        n_idx   = r_idx;
        case (r_phase)
            P_SIGN: begin
                n_phase = P_WHOLE;
                n_idx   = r_rec.wcnt - 3'd1;
            end
            P_WHOLE: begin
                ch = f16dt_pkg::CH_ZERO + {4'd0, r_rec.wdig[r_idx]};
                if (r_idx == 3'd0) begin
                    ch_last = !r_rec.fnz;
                    n_phase = P_POINT;
                end else begin
                    n_idx = r_idx - 3'd1;
                end
            end
            P_POINT: begin
                ch      = f16dt_pkg::CH_POINT;
                n_phase = P_FRAC;
                n_idx   = 3'(f16dt_pkg::FRAC_DIGITS - 1);
            end
            P_FRAC: begin
                ch      = f16dt_pkg::CH_ZERO + {4'd0, r_rec.fdig[r_idx[1:0]]};
                ch_last = (r_idx[1:0] == r_rec.fstop);
                n_idx   = r_idx - 3'd1;
            end
            default: begin
                n_phase = P_SIGN;
            end
        endcase
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_phase  <= P_SIGN;
        end else if (load) begin
            r_active <= 1'b1;
            r_phase  <= i_rec.neg ? P_SIGN : P_WHOLE;
        end else if (emit) begin
            r_active <= !ch_last;
            r_phase  <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rec <= i_rec;
            r_idx <= i_rec.wcnt - 3'd1;
        end else if (emit) begin
            r_idx <= n_idx;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (slot_free) begin
            r_ov <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_char <= ch;
            r_last <= ch_last;
        end
    end

    assign o_valid     = r_ov;
    assign o_text_char = r_char;
    assign o_last_char = r_last;

endmodule

[sim/fixed16_16_to_decimal_text_tb.sv]
`timescale 1ns / 1ps

module fixed16_16_to_decimal_text_tb;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_ITEMS  = 100;
    localparam int PRINT_CAP    = 100;

    // One expected character, tagged with the number it came from
    typedef struct packed {
        logic [31:0] src;
        logic [7:0]  ch;
        logic        last;
    } t_char_exp;

    // Directed row: empty text means the predictor supplies the characters
    typedef struct {
        logic [31:0] value;
        string       text;
    } t_stim_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic signed [31:0] i_fixed_value = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [7:0]         o_text_char;
    logic               o_last_char;

    t_char_exp pending_chars[$];
    t_char_exp head_char;
    t_stim_row dir_rows[$];
    int        err_count = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;

    fixed16_16_to_decimal_text i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_fixed_value (i_fixed_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_text_char   (o_text_char),
        .o_last_char   (o_last_char)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (err_count < PRINT_CAP) begin
            $display("MISMATCH @%0t: %s", $realtime, msg);
        end
        err_count++;
    endtask

    // Decimal text of one signed 16.16 number, queued as expected characters
    task automatic predict_text(input logic [31:0] raw);
        logic [7:0]  chars [11];
        logic [7:0]  wdig [5];
        logic [7:0]  fdig [4];
        logic [31:0] mag;
        logic [15:0] whole;
        logic [15:0] frac;
        logic [31:0] scaled;
        t_char_exp   item;
        int          n;
        int          m;
        int          keep;
        n = 0;
        m = 0;
        // magnitude wraps, so the most negative value keeps bit 31
        mag   = raw[31] ? (32'd0 - raw) : raw;
        whole = mag[31:16];
        frac  = mag[15:0];
        if (raw[31]) begin
            chars[n] = f16dt_pkg::CH_MINUS;
            n++;
        end
        if (whole == 16'd0) begin
            wdig[0] = f16dt_pkg::CH_ZERO;
            m = 1;
        end else begin
            while (whole != 16'd0) begin
                wdig[m] = f16dt_pkg::CH_ZERO + 8'(whole % 16'd10);
                whole   = whole / 16'd10;
                m++;
            end
        end
        while (m > 0) begin
            m--;
            chars[n] = wdig[m];
            n++;
        end
        // four truncated fraction digits, trailing zeros dropped, one kept
        if (frac != 16'd0) begin
            scaled  = ({16'd0, frac} * 32'd10000) >> 16;
            fdig[0] = f16dt_pkg::CH_ZERO + 8'((scaled / 32'd1000) % 32'd10);
            fdig[1] = f16dt_pkg::CH_ZERO + 8'((scaled / 32'd100) % 32'd10);
            fdig[2] = f16dt_pkg::CH_ZERO + 8'((scaled / 32'd10) % 32'd10);
            fdig[3] = f16dt_pkg::CH_ZERO + 8'(scaled % 32'd10);
            keep = 4;
            while (keep > 1 && fdig[keep-1] == f16dt_pkg::CH_ZERO) keep--;
            chars[n] = f16dt_pkg::CH_POINT;
            n++;
            for (int k = 0; k < keep; k++) begin
                chars[n] = fdig[k];
                n++;
            end
        end
        for (int k = 0; k < n; k++) begin
            item.src  = raw;
            item.ch   = chars[k];
            item.last = (k == n - 1);
            pending_chars.push_back(item);
        end
    endtask

    // Random number, biased toward integers, tiny magnitudes, sparse fractions and range ends
    function automatic logic [31:0] random_value();
        int          pick;
        logic [15:0] whole;
        logic [15:0] frac;
        pick  = $urandom_range(0, 99);
        whole = 16'($urandom);
        frac  = 16'($urandom);
        if (pick < 30) begin
            return $urandom;
        end else if (pick < 50) begin
            frac = 16'd0;
        end else if (pick < 70) begin
            case ($urandom_range(0, 5))
                0: whole = 16'h0000;
                1: whole = 16'h0001;
                2: whole = 16'h0002;
                3: whole = 16'hFFFF;
                4: whole = 16'hFFFE;
                default: whole = 16'hFFFD;
            endcase
        end else if (pick < 85) begin
            if ($urandom_range(0, 1) == 0) begin
                frac = 16'($urandom_range(0, 15)) << 12;
            end else begin
                frac = 16'd1 << $urandom_range(0, 15);
            end
        end else begin
            case ($urandom_range(0, 4))
                0: whole = 16'h7FFF;
                1: whole = 16'h8000;
                2: whole = 16'h8001;
                3: whole = 16'hFFFF;
                default: whole = 16'h0000;
            endcase
            case ($urandom_range(0, 2))
                0: frac = 16'h0000;
                1: frac = 16'hFFFF;
                default: frac = 16'($urandom);
            endcase
        end
        return {whole, frac};
    endfunction

    // Offer one item, with random idle cycles first; expectations queue on accept
    task automatic send_item(input logic [31:0] value, input string text);
        t_char_exp item;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_fixed_value <= value;
        do @(posedge i_clk); while (!o_ready);
        if (text.len() == 0) begin
            predict_text(value);
        end else begin
            for (int k = 0; k < text.len(); k++) begin
                item.src  = value;
                item.ch   = text[k];
                item.last = (k == text.len() - 1);
                pending_chars.push_back(item);
            end
        end
    endtask

    // Stop offering and wait for every expected character
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
    endtask

    // Output side: check each accepted character, then pick next ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected char %h last %b",
                                          o_text_char, o_last_char));
            end else begin
                head_char = pending_chars.pop_front();
                if (o_text_char !== head_char.ch) begin
                    report_mismatch($sformatf("value %h: char got %h want %h",
                                              head_char.src, o_text_char, head_char.ch));
                end
                if (o_last_char !== head_char.last) begin
                    report_mismatch($sformatf("value %h: last got %b want %b",
                                              head_char.src, o_last_char, head_char.last));
                end
            end
        end
        i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("fixed16_16_to_decimal_text_tb: done, errors");
        $finish;
    end

    initial begin
        // Directed rows: range ends, sign, zero parts, digit stripping
        dir_rows.push_back('{32'h00000000, "0"});
        dir_rows.push_back('{32'h00010000, "1"});
        dir_rows.push_back('{32'hFFFF0000, "-1"});
        dir_rows.push_back('{32'h7FFFFFFF, "32767.9999"});
        dir_rows.push_back('{32'h80000000, "-32768"});
        dir_rows.push_back('{32'h80000001, "-32767.9999"});
        dir_rows.push_back('{32'h7FFF0000, "32767"});
        dir_rows.push_back('{32'h00000001, "0.0"});
        dir_rows.push_back('{32'hFFFFFFFF, "-0.0"});
        dir_rows.push_back('{32'h00008000, "0.5"});
        dir_rows.push_back('{32'hFFFF8000, "-0.5"});
        dir_rows.push_back('{32'h00004000, "0.25"});
        dir_rows.push_back('{32'h00001000, "0.0625"});
        dir_rows.push_back('{32'h0000FFFF, "0.9999"});
        dir_rows.push_back('{32'h0000199A, "0.1"});
        dir_rows.push_back('{32'h000A0000, "10"});
        dir_rows.push_back('{32'h00640000, "100"});
        dir_rows.push_back('{32'h27100000, "10000"});
        dir_rows.push_back('{32'h12345678, ""});
        dir_rows.push_back('{32'hDEADBEEF, ""});
        dir_rows.push_back('{32'h00030020, ""});
        dir_rows.push_back('{32'hAAAA5555, ""});
        dir_rows.push_back('{32'h5555AAAA, ""});

        // Reset
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, back to back
        foreach (dir_rows[r]) send_item(dir_rows[r].value, dir_rows[r].text);
        wait_drained();

        // Random part in three phases of sender and receiver idling (none in the last), fully drained between them
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 30;
                    recv_idle_pct = 49;
                end
                1: begin
                    send_idle_pct = 49;
                    recv_idle_pct = 30;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) send_item(random_value(), "");
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_chars.size() != 0) begin
            report_mismatch($sformatf("%0d chars never arrived", pending_chars.size()));
        end
        if (err_count == 0) begin
            $display("fixed16_16_to_decimal_text_tb: done, clean");
        end else begin
            $display("fixed16_16_to_decimal_text_tb: done, errors");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/f16dt_pkg.sv
hw/rtl/f16dt_front.sv
hw/rtl/f16dt_queue.sv
hw/rtl/f16dt_back.sv
hw/rtl/fixed16_16_to_decimal_text.sv
sim/fixed16_16_to_decimal_text_tb.sv
